### src/pphf_pkg.sv
// ----------------------------------------------------------------------------
// pphf_pkg
// shared constants, codes and state types of the protocol/port hash filter
// ----------------------------------------------------------------------------
package pphf_pkg;

	localparam int BUCKETS_DEF = 1024;
	localparam int POOL_DEF    = 1024;
	localparam int HASH_SHIFT  = 5;
	localparam int HASH_W      = 17;
	localparam int MOD_W       = 11;
	localparam int MOD_RESET   = 1021;
	localparam int PROTO_W     = 8;
	localparam int PORT_W      = 16;
	localparam int STAT_W      = 3;
	localparam int BKT_OUT_W   = 10;
	localparam int IDX_W       = 1;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_LOOKUP = 1'b1
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_MISS     = 3'd0,
		ST_HIT      = 3'd1,
		ST_DISABLED = 3'd2,
		ST_STORED   = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef enum logic [IDX_W-1:0] {
		REG_MODULUS = 1'b0,
		REG_DISABLE = 1'b1
	} reg_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_HCHK,
		B_PCHK,
		B_FRESH,
		B_DONE
	} back_state_t;

	typedef struct packed {
		logic    q_push;
		logic    q_full;
		logic    q_empty;
		logic    q_pop;
	} q_ctrl_t;

endpackage

### src/pphf_ram.sv
// ----------------------------------------------------------------------------
// pphf_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module pphf_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
	input  logic [W-1:0]                  wdata,
	input  logic                          re,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
	output logic [W-1:0]                  rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/pphf_front.sv
// ----------------------------------------------------------------------------
// pphf_front
// accepts words, hashes the pair and finds the bucket with a bit-serial
// remainder, then hands the classified word to the queue
// ----------------------------------------------------------------------------
module pphf_front #(
	parameter int BUCKETS = pphf_pkg::BUCKETS_DEF,
	parameter int BW      = $clog2(BUCKETS),
	parameter int IW      = 1 + pphf_pkg::PROTO_W + pphf_pkg::PORT_W + BW
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         in_op,
	input  logic [pphf_pkg::PROTO_W-1:0] in_proto,
	input  logic [pphf_pkg::PORT_W-1:0]  in_port,
	input  logic [pphf_pkg::MOD_W-1:0]   modulus,
	output logic                         push,
	input  logic                         full,
	output logic [IW-1:0]                item
);

	localparam int MW = BW + 1;
	localparam int CW = (pphf_pkg::MOD_W > MW) ? pphf_pkg::MOD_W : MW;
	localparam int NW = $clog2(pphf_pkg::HASH_W);

	pphf_pkg::front_state_t state_q, state_d;
	logic [NW-1:0]                cnt_q;
	logic [pphf_pkg::HASH_W-1:0]  dvd_q;
	logic [MW-1:0]                rem_q;
	logic [MW-1:0]                m_q;
	logic                         op_q;
	logic [pphf_pkg::PROTO_W-1:0] proto_q;
	logic [pphf_pkg::PORT_W-1:0]  port_q;

	logic [pphf_pkg::HASH_W-1:0]  hash;
	logic [CW-1:0]                mod_ext;
	logic [MW-1:0]                m_sel;
	logic [MW:0]                  sh;
	logic [MW:0]                  sub;
	logic [MW-1:0]                rem_nx;
	logic                         accept;

	assign hash = (pphf_pkg::HASH_W'(in_proto) << pphf_pkg::HASH_SHIFT)
		+ pphf_pkg::HASH_W'(in_proto) + pphf_pkg::HASH_W'(in_port);
	assign mod_ext = CW'(modulus);

	always_comb begin
		if (modulus == '0) begin
			m_sel = MW'(1);
		end else if (mod_ext > CW'(BUCKETS)) begin
			m_sel = MW'(BUCKETS);
		end else begin
			m_sel = MW'(mod_ext);
		end
	end

	assign sh     = {rem_q, dvd_q[pphf_pkg::HASH_W-1]};
	assign sub    = sh - {1'b0, m_q};
	assign rem_nx = (sh >= {1'b0, m_q}) ? sub[MW-1:0] : sh[MW-1:0];

	assign in_ready = (state_q == pphf_pkg::F_IDLE);
	assign accept   = in_valid && in_ready;
	assign item     = {op_q, proto_q, port_q, rem_q[BW-1:0]};

	always_comb begin
		state_d = state_q;
		push    = 1'b0;
		unique case (state_q)
			pphf_pkg::F_IDLE: begin
				if (in_valid) state_d = pphf_pkg::F_DIV;
			end
			pphf_pkg::F_DIV: begin
				if (cnt_q == NW'(pphf_pkg::HASH_W - 1)) state_d = pphf_pkg::F_PUSH;
			end
			pphf_pkg::F_PUSH: begin
				push = !full;
				if (!full) state_d = pphf_pkg::F_IDLE;
			end
			default: state_d = pphf_pkg::F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pphf_pkg::F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dvd_q   <= hash;
			rem_q   <= '0;
			cnt_q   <= '0;
			m_q     <= m_sel;
			op_q    <= in_op;
			proto_q <= in_proto;
			port_q  <= in_port;
		end else if (state_q == pphf_pkg::F_DIV) begin
			rem_q <= rem_nx;
			dvd_q <= dvd_q << 1;
			cnt_q <= cnt_q + NW'(1);
		end
	end

endmodule

### src/pphf_fifo.sv
// ----------------------------------------------------------------------------
// pphf_fifo
// two-entry queue between the classifying front and the table sequencer
// ----------------------------------------------------------------------------
module pphf_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);

	logic [W-1:0] mem_q [2];
	logic         wp_q;
	logic         rp_q;
	logic [1:0]   cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign dout  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= din;
	end

endmodule

### src/pphf_back.sv
// ----------------------------------------------------------------------------
// pphf_back
// table sequencer: clears the heads after reset, inserts and walks chains,
// and holds the result word
// ----------------------------------------------------------------------------
module pphf_back #(
	parameter int BUCKETS      = pphf_pkg::BUCKETS_DEF,
	parameter int POOL_ENTRIES = pphf_pkg::POOL_DEF,
	parameter int BW           = $clog2(BUCKETS),
	parameter int IW           = 1 + pphf_pkg::PROTO_W + pphf_pkg::PORT_W + BW
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	output logic                           q_pop,
	input  logic [IW-1:0]                  q_item,
	input  logic                           disabled,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [pphf_pkg::STAT_W-1:0]    out_status,
	output logic [pphf_pkg::BKT_OUT_W-1:0] out_bucket
);

	localparam int LW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
	localparam int CNW = $clog2(POOL_ENTRIES + 1);

	typedef struct packed {
		logic [pphf_pkg::PROTO_W-1:0] proto;
		logic [pphf_pkg::PORT_W-1:0]  port;
		logic                         has_link;
		logic [LW-1:0]                link;
	} entry_t;

	localparam int EW = $bits(entry_t);

	pphf_pkg::back_state_t state_q, state_d;
	logic [BW-1:0]                clr_q;
	logic                         op_q;
	logic [pphf_pkg::PROTO_W-1:0] proto_q;
	logic [pphf_pkg::PORT_W-1:0]  port_q;
	logic [BW-1:0]                bkt_q;
	logic [LW-1:0]                idx_q, idx_d;
	logic [CNW-1:0]               used_q;
	pphf_pkg::status_t            stat_q, stat_d;
	logic                         ovalid_q;
	pphf_pkg::status_t            ostat_q;
	logic [pphf_pkg::BKT_OUT_W-1:0] obkt_q;

	logic          i_op;
	logic [pphf_pkg::PROTO_W-1:0] i_proto;
	logic [pphf_pkg::PORT_W-1:0]  i_port;
	logic [BW-1:0] i_bkt;

	logic          h_we, h_re, p_we, p_re;
	logic [BW-1:0] h_waddr, h_raddr;
	logic [LW-1:0] p_waddr, p_raddr;
	entry_t        h_wdata, p_wdata, h, p;
	logic [EW-1:0] h_rd, p_rd;
	logic          full_pool, load_out, bump;
	logic [LW-1:0] fresh;

	assign {i_op, i_proto, i_port, i_bkt} = q_item;
	assign h = h_rd;
	assign p = p_rd;
	assign full_pool = (used_q == CNW'(POOL_ENTRIES));
	assign fresh = LW'(used_q);

	pphf_ram #(.W(EW), .D(BUCKETS)) u_heads (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.re(h_re), .raddr(h_raddr), .rdata(h_rd)
	);

	pphf_ram #(.W(EW), .D(POOL_ENTRIES)) u_pool (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.re(p_re), .raddr(p_raddr), .rdata(p_rd)
	);

	always_comb begin
		state_d  = state_q;
		stat_d   = stat_q;
		idx_d    = idx_q;
		q_pop    = 1'b0;
		h_we     = 1'b0;
		h_waddr  = bkt_q;
		h_wdata  = '0;
		h_re     = 1'b0;
		h_raddr  = i_bkt;
		p_we     = 1'b0;
		p_waddr  = fresh;
		p_wdata  = '0;
		p_re     = 1'b0;
		p_raddr  = h.link;
		load_out = 1'b0;
		bump     = 1'b0;
		unique case (state_q)
			pphf_pkg::B_CLEAR: begin
				h_we    = 1'b1;
				h_waddr = clr_q;
				if (clr_q == BW'(BUCKETS - 1)) state_d = pphf_pkg::B_IDLE;
			end
			pphf_pkg::B_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					h_re    = 1'b1;
					state_d = pphf_pkg::B_HCHK;
				end
			end
			pphf_pkg::B_HCHK: begin
				state_d = pphf_pkg::B_DONE;
				if (op_q == pphf_pkg::OP_INSERT) begin
					if (h.proto == '0) begin
						h_we    = 1'b1;
						h_wdata = '{proto: proto_q, port: port_q,
							has_link: h.has_link, link: h.link};
						stat_d  = pphf_pkg::ST_STORED;
					end else if (full_pool) begin
						stat_d = pphf_pkg::ST_FULL;
					end else if (!h.has_link) begin
						h_we    = 1'b1;
						h_wdata = '{proto: h.proto, port: h.port, has_link: 1'b1, link: fresh};
						state_d = pphf_pkg::B_FRESH;
					end else begin
						p_re    = 1'b1;
						idx_d   = h.link;
						state_d = pphf_pkg::B_PCHK;
					end
				end else begin
					if (disabled) begin
						stat_d = pphf_pkg::ST_DISABLED;
					end else if (proto_q == '0 || h.proto == '0) begin
						stat_d = pphf_pkg::ST_MISS;
					end else if (h.proto == proto_q && h.port == port_q) begin
						stat_d = pphf_pkg::ST_HIT;
					end else if (!h.has_link) begin
						stat_d = pphf_pkg::ST_MISS;
					end else begin
						p_re    = 1'b1;
						idx_d   = h.link;
						state_d = pphf_pkg::B_PCHK;
					end
				end
			end
			pphf_pkg::B_PCHK: begin
				p_raddr = p.link;
				if (op_q == pphf_pkg::OP_INSERT) begin
					if (!p.has_link) begin
						p_we    = 1'b1;
						p_waddr = idx_q;
						p_wdata = '{proto: p.proto, port: p.port, has_link: 1'b1, link: fresh};
						state_d = pphf_pkg::B_FRESH;
					end else begin
						p_re  = 1'b1;
						idx_d = p.link;
					end
				end else begin
					if (p.proto == proto_q && p.port == port_q) begin
						stat_d  = pphf_pkg::ST_HIT;
						state_d = pphf_pkg::B_DONE;
					end else if (!p.has_link) begin
						stat_d  = pphf_pkg::ST_MISS;
						state_d = pphf_pkg::B_DONE;
					end else begin
						p_re  = 1'b1;
						idx_d = p.link;
					end
				end
			end
			pphf_pkg::B_FRESH: begin
				p_we    = 1'b1;
				p_wdata = '{proto: proto_q, port: port_q, has_link: 1'b0, link: '0};
				bump    = 1'b1;
				stat_d  = pphf_pkg::ST_STORED;
				state_d = pphf_pkg::B_DONE;
			end
			pphf_pkg::B_DONE: begin
				if (!ovalid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = pphf_pkg::B_IDLE;
				end
			end
			default: state_d = pphf_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= pphf_pkg::B_CLEAR;
			clr_q    <= '0;
			used_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == pphf_pkg::B_CLEAR) clr_q <= clr_q + BW'(1);
			if (bump) used_q <= used_q + CNW'(1);
			if (load_out) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_q    <= i_op;
			proto_q <= i_proto;
			port_q  <= i_port;
			bkt_q   <= i_bkt;
		end
		idx_q  <= idx_d;
		stat_q <= stat_d;
		if (load_out) begin
			ostat_q <= stat_q;
			obkt_q  <= pphf_pkg::BKT_OUT_W'(bkt_q);
		end
	end

	assign out_valid  = ovalid_q;
	assign out_status = ostat_q;
	assign out_bucket = obkt_q;

endmodule

### src/protocol_port_hash_filter.sv
// ----------------------------------------------------------------------------
// protocol_port_hash_filter
// membership filter over protocol/port pairs in a chained hash table
// ----------------------------------------------------------------------------
// When no pool entry is walked, a word's result passes these steps after it is
// accepted: the bit-serial remainder, the push into the queue, the pop with the
// bucket head read, the head check and the load of the result register. Each
// pool entry walked adds a check step, and an insert that appends to a chain
// adds a step that writes the fresh entry. The front takes a new word only after
// it has pushed the last one, which waits while the queue is full; the two-word
// queue lets it go on while the table sequencer walks a long chain. After reset
// the sequencer clears the bucket heads, one per cycle, before taking the first
// word; the front can still accept and queue words then.
module protocol_port_hash_filter #(
	parameter int BUCKETS      = pphf_pkg::BUCKETS_DEF,
	parameter int POOL_ENTRIES = pphf_pkg::POOL_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // protocol[7:0], port[23:8]
	input  logic [0:0]  s_tuser,   // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // bucket[9:0], zero fill
	output logic [2:0]  m_tuser,   // status
	input  logic        cfg_we,
	input  logic [pphf_pkg::IDX_W-1:0] cfg_index,
	input  logic [pphf_pkg::MOD_W-1:0] cfg_data
);

	localparam int BW = $clog2(BUCKETS);
	localparam int IW = 1 + pphf_pkg::PROTO_W + pphf_pkg::PORT_W + BW;

	logic [pphf_pkg::MOD_W-1:0]     modulus_q;
	logic                           disabled_q;
	pphf_pkg::q_ctrl_t              qc;
	logic [IW-1:0]                  f_item, q_item;
	logic [pphf_pkg::BKT_OUT_W-1:0] bkt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= pphf_pkg::MOD_W'(pphf_pkg::MOD_RESET);
			disabled_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pphf_pkg::REG_MODULUS: modulus_q  <= cfg_data;
				pphf_pkg::REG_DISABLE: disabled_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	pphf_front #(.BUCKETS(BUCKETS), .BW(BW), .IW(IW)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.in_op(s_tuser[0]), .in_proto(s_tdata[7:0]), .in_port(s_tdata[23:8]),
		.modulus(modulus_q), .push(qc.q_push), .full(qc.q_full), .item(f_item)
	);

	pphf_fifo #(.W(IW)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(qc.q_push), .din(f_item), .full(qc.q_full),
		.pop(qc.q_pop), .dout(q_item), .empty(qc.q_empty)
	);

	pphf_back #(.BUCKETS(BUCKETS), .POOL_ENTRIES(POOL_ENTRIES), .BW(BW), .IW(IW)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(!qc.q_empty), .q_pop(qc.q_pop), .q_item(q_item),
		.disabled(disabled_q),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_status(m_tuser), .out_bucket(bkt)
	);

	assign m_tdata = {6'b0, bkt};

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(qc.q_push && qc.q_full))
		else $error("queue pushed while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(qc.q_pop && qc.q_empty))
		else $error("queue popped while empty");

	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("front took a word while dividing");

	a_disabled_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == pphf_pkg::ST_DISABLED |-> disabled_q)
		else $error("disabled status while filter enabled");

endmodule
